FILE: design/oi_pkg.sv
// oi_pkg: shared types and constants for the orientation integrator.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package oi_pkg;

   localparam int OI_ORIENT_WIDTH = 32;
   localparam int OI_ORIENT_FRAC  = 28;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_METHOD    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_STEP = 2'd1;

   localparam logic [1:0] METHOD_MATRIX = 2'd0;
   localparam logic [1:0] METHOD_QUAT   = 2'd2;

   localparam logic [31:0] TIME_STEP_RESET = 32'd42949673;

   typedef struct packed {
      logic signed [31:0] omega_x;
      logic signed [31:0] omega_y;
      logic signed [31:0] omega_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] elem0;
      logic signed [31:0] elem1;
      logic signed [31:0] elem2;
      logic signed [31:0] elem3;
      logic signed [31:0] elem4;
      logic signed [31:0] elem5;
      logic signed [31:0] elem6;
      logic signed [31:0] elem7;
      logic signed [31:0] elem8;
      logic [31:0]        step_count;
      logic [63:0]        elapsed_time;
      logic               bad_method;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic quat;
      logic ack;
   } oi_cmd_type;

endpackage
`default_nettype wire

FILE: design/oi_core.sv
// oi_core: orientation state and the sequenced arithmetic for one tick.
// One shift-add multiplier / compare-subtract accumulator under a sequencer.
// Depends on oi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oi_core import oi_pkg::*; #(
   parameter int ORIENT_WIDTH = OI_ORIENT_WIDTH,
   parameter int ORIENT_FRAC  = OI_ORIENT_FRAC
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire oi_cmd_type                     cmd,
   input  wire logic [31:0]                    dt,
   input  wire req_type                        omega,
   output logic                                done,
   output logic [8:0][ORIENT_WIDTH-1:0]        mat,
   output logic [3:0][ORIENT_WIDTH-1:0]        quat
);

   localparam int W    = ORIENT_WIDTH;
   localparam int F    = ORIENT_FRAC;
   localparam int AW   = (2*W+34 > W+68) ? 2*W+34 : W+68;
   localparam int AMW  = W+15;
   localparam int MW   = (AMW > 32) ? AMW : 32;
   localparam int QW   = 2*F+4;
   localparam int RW   = F+2;
   localparam int SRW  = F+6;
   localparam int CNTW = $clog2(QW);
   localparam int NW   = ((RW > W) ? RW : W) + 1;

   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] UNIT = (F <= W-2) ? (W'(1) << F) : SMAX;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_HSET = 5'd1;
   localparam logic [4:0] S_MUL  = 5'd2;
   localparam logic [4:0] S_HSTO = 5'd3;
   localparam logic [4:0] S_MINI = 5'd4;
   localparam logic [4:0] S_MTRM = 5'd5;
   localparam logic [4:0] S_MNXT = 5'd6;
   localparam logic [4:0] S_MSTO = 5'd7;
   localparam logic [4:0] S_MCPY = 5'd8;
   localparam logic [4:0] S_QINI = 5'd9;
   localparam logic [4:0] S_QTRM = 5'd10;
   localparam logic [4:0] S_QNXT = 5'd11;
   localparam logic [4:0] S_QSTO = 5'd12;
   localparam logic [4:0] S_SSET = 5'd13;
   localparam logic [4:0] S_SNXT = 5'd14;
   localparam logic [4:0] S_NSET = 5'd15;
   localparam logic [4:0] S_DIVI = 5'd16;
   localparam logic [4:0] S_DIV  = 5'd17;
   localparam logic [4:0] S_SQI  = 5'd18;
   localparam logic [4:0] S_SQ   = 5'd19;
   localparam logic [4:0] S_NOUT = 5'd20;
   localparam logic [4:0] S_DONE = 5'd21;

   typedef struct packed {
      logic       neg;
      logic [1:0] hi;
      logic [1:0] si;
   } term_type;

   // skew(w)*R: two nonzero terms per row
   function automatic term_type mterm(input logic [1:0] row, input logic t);
      term_type r;
      case ({row, t})
         3'b000:  r = '{neg: 1'b1, hi: 2'd2, si: 2'd1};
         3'b001:  r = '{neg: 1'b0, hi: 2'd1, si: 2'd2};
         3'b010:  r = '{neg: 1'b0, hi: 2'd2, si: 2'd0};
         3'b011:  r = '{neg: 1'b1, hi: 2'd0, si: 2'd2};
         3'b100:  r = '{neg: 1'b1, hi: 2'd1, si: 2'd0};
         3'b101:  r = '{neg: 1'b0, hi: 2'd0, si: 2'd1};
         default: r = '{neg: 1'b0, hi: 2'd0, si: 2'd0};
      endcase
      return r;
   endfunction

   // (0,w)*q: three terms per component
   function automatic term_type qterm(input logic [1:0] e, input logic [1:0] t);
      term_type r;
      case ({e, t})
         4'b0000: r = '{neg: 1'b1, hi: 2'd0, si: 2'd1};
         4'b0001: r = '{neg: 1'b1, hi: 2'd1, si: 2'd2};
         4'b0010: r = '{neg: 1'b1, hi: 2'd2, si: 2'd3};
         4'b0100: r = '{neg: 1'b0, hi: 2'd0, si: 2'd0};
         4'b0101: r = '{neg: 1'b0, hi: 2'd1, si: 2'd3};
         4'b0110: r = '{neg: 1'b1, hi: 2'd2, si: 2'd2};
         4'b1000: r = '{neg: 1'b0, hi: 2'd1, si: 2'd0};
         4'b1001: r = '{neg: 1'b0, hi: 2'd2, si: 2'd1};
         4'b1010: r = '{neg: 1'b1, hi: 2'd0, si: 2'd3};
         4'b1100: r = '{neg: 1'b0, hi: 2'd2, si: 2'd0};
         4'b1101: r = '{neg: 1'b0, hi: 2'd0, si: 2'd2};
         4'b1110: r = '{neg: 1'b1, hi: 2'd1, si: 2'd1};
         default: r = '{neg: 1'b0, hi: 2'd0, si: 2'd0};
      endcase
      return r;
   endfunction

   function automatic logic [1:0] row_of(input logic [3:0] e);
      logic [1:0] r;
      case (e) inside
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   logic [4:0]             state_ff, state_in, ret_ff, ret_in;
   logic [3:0]             e_ff, e_in;
   logic [1:0]             t_ff, t_in;
   logic                   qmode_ff, qmode_in;
   logic signed [W-1:0]    r_ff [9];
   logic signed [W-1:0]    r_in [9];
   logic signed [W-1:0]    nm_ff [9];
   logic signed [W-1:0]    nm_in [9];
   logic signed [W-1:0]    q_ff [4];
   logic signed [W-1:0]    q_in [4];
   logic signed [63:0]     h_ff [3];
   logic signed [63:0]     h_in [3];
   logic [AMW-1:0]         a_ff [4];
   logic [AMW-1:0]         a_in [4];
   logic [3:0]             sg_ff, sg_in;
   logic [AW-1:0]          s_ff, s_in;
   logic signed [AW-1:0]   acc_ff, acc_in, mcand_ff, mcand_in;
   logic [MW-1:0]          mplier_ff, mplier_in;
   logic [QW-1:0]          dq_ff, dq_in;
   logic [RW-1:0]          root_ff, root_in;
   logic [SRW-1:0]         rq_ff, rq_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;

   // datapath terms
   logic [1:0]             row, col;
   logic [3:0]             three_row;
   term_type               mt, qt;
   logic signed [W-1:0]    msrc, qsrc;
   logic [W-1:0]           msrc_mag, qsrc_mag;
   logic signed [AW-1:0]   mhx, qhx;
   logic signed [31:0]     om_sel;
   logic signed [AW-1:0]   mrnd, msh, prnd, psh, pabs;
   logic [AW-W:0]          mtop;
   logic signed [W-1:0]    mclamp;
   logic                   pneg;
   logic                   dge;
   logic [AW-1:0]          dvr;
   logic [SRW-1:0]         r2, trial;
   logic                   sge;
   logic [RW:0]            lo_full;
   logic [RW-1:0]          lo;
   logic signed [NW-1:0]   nv;
   logic [NW-W:0]          ntop;
   logic signed [W-1:0]    nclamp;

   always_comb begin
      row       = row_of(e_ff);
      three_row = {2'b00, row} + {1'b0, row, 1'b0};
      col       = 2'(e_ff - three_row);
      mt        = mterm(row, t_ff[0]);
      qt        = qterm(e_ff[1:0], t_ff);
      msrc      = r_ff[4'({2'b00, mt.si} + {1'b0, mt.si, 1'b0} + {2'b00, col})];
      qsrc      = q_ff[qt.si];
      msrc_mag  = msrc[W-1] ? (~msrc + W'(1)) : msrc;
      qsrc_mag  = qsrc[W-1] ? (~qsrc + W'(1)) : qsrc;
      mhx       = AW'(h_ff[mt.hi]);
      qhx       = AW'(h_ff[qt.hi]);
      case (e_ff[1:0])
         2'd0:    om_sel = omega.omega_x;
         2'd1:    om_sel = omega.omega_y;
         default: om_sel = omega.omega_z;
      endcase

      mrnd   = acc_ff + (AW'(1) <<< 51);
      msh    = mrnd >>> 52;
      mtop   = msh[AW-1:W-1];
      mclamp = ((&mtop) | ~(|mtop)) ? msh[W-1:0] : (msh[AW-1] ? SMIN : SMAX);

      prnd   = acc_ff + (AW'(1) <<< 50);
      psh    = prnd >>> 51;
      pneg   = psh[AW-1];
      pabs   = pneg ? -psh : psh;

      dge    = $unsigned(acc_ff) >= s_ff;
      dvr    = dge ? ($unsigned(acc_ff) - s_ff) : $unsigned(acc_ff);

      r2     = {rq_ff[SRW-3:0], dq_ff[QW-1:QW-2]};
      trial  = SRW'({root_ff, 2'b01});
      sge    = r2 >= trial;

      lo_full = {1'b0, root_ff} + (RW+1)'(1);
      lo      = lo_full[RW:1];
      nv      = sg_ff[e_ff[1:0]] ? -$signed(NW'(lo)) : $signed(NW'(lo));
      ntop    = nv[NW-1:W-1];
      nclamp  = ((&ntop) | ~(|ntop)) ? nv[W-1:0] : (nv[NW-1] ? SMIN : SMAX);
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      e_in      = e_ff;
      t_in      = t_ff;
      qmode_in  = qmode_ff;
      r_in      = r_ff;
      nm_in     = nm_ff;
      q_in      = q_ff;
      h_in      = h_ff;
      a_in      = a_ff;
      sg_in     = sg_ff;
      s_in      = s_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      dq_in     = dq_ff;
      root_in   = root_ff;
      rq_in     = rq_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               e_in     = '0;
               qmode_in = cmd.quat;
               state_in = S_HSET;
            end
         end
         S_HSET: begin
            acc_in    = '0;
            mcand_in  = AW'(om_sel);
            mplier_in = MW'(dt);
            ret_in    = S_HSTO;
            state_in  = S_MUL;
         end
         S_MUL: begin
            if (mplier_ff == '0) begin
               state_in = ret_ff;
            end else begin
               if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
               mcand_in  = mcand_ff <<< 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         S_HSTO: begin
            h_in[e_ff[1:0]] = acc_ff[63:0];
            if (e_ff == 4'd2) begin
               e_in     = '0;
               state_in = qmode_ff ? S_QINI : S_MINI;
            end else begin
               e_in     = e_ff + 4'd1;
               state_in = S_HSET;
            end
         end
         S_MINI: begin
            acc_in   = AW'(r_ff[e_ff]) <<< 52;
            t_in     = '0;
            state_in = S_MTRM;
         end
         S_MTRM: begin
            mcand_in  = (mt.neg ^ msrc[W-1]) ? -mhx : mhx;
            mplier_in = MW'(msrc_mag);
            ret_in    = S_MNXT;
            state_in  = S_MUL;
         end
         S_MNXT: begin
            if (t_ff == 2'd0) begin
               t_in     = 2'd1;
               state_in = S_MTRM;
            end else begin
               state_in = S_MSTO;
            end
         end
         S_MSTO: begin
            nm_in[e_ff] = mclamp;
            if (e_ff == 4'd8) begin
               state_in = S_MCPY;
            end else begin
               e_in     = e_ff + 4'd1;
               state_in = S_MINI;
            end
         end
         S_MCPY: begin
            r_in     = nm_ff;
            state_in = S_DONE;
         end
         S_QINI: begin
            acc_in   = AW'(q_ff[e_ff[1:0]]) <<< 53;
            t_in     = '0;
            state_in = S_QTRM;
         end
         S_QTRM: begin
            mcand_in  = (qt.neg ^ qsrc[W-1]) ? -qhx : qhx;
            mplier_in = MW'(qsrc_mag);
            ret_in    = S_QNXT;
            state_in  = S_MUL;
         end
         S_QNXT: begin
            if (t_ff != 2'd2) begin
               t_in     = t_ff + 2'd1;
               state_in = S_QTRM;
            end else begin
               state_in = S_QSTO;
            end
         end
         S_QSTO: begin
            a_in[e_ff[1:0]]  = pabs[AMW-1:0];
            sg_in[e_ff[1:0]] = pneg;
            if (e_ff == 4'd3) begin
               e_in     = '0;
               acc_in   = '0;
               state_in = S_SSET;
            end else begin
               e_in     = e_ff + 4'd1;
               state_in = S_QINI;
            end
         end
         S_SSET: begin
            mcand_in  = $signed(AW'(a_ff[e_ff[1:0]]));
            mplier_in = MW'(a_ff[e_ff[1:0]]);
            ret_in    = S_SNXT;
            state_in  = S_MUL;
         end
         S_SNXT: begin
            if (e_ff == 4'd3) begin
               s_in     = $unsigned(acc_ff);
               e_in     = '0;
               // all-zero quaternion: keep the old one
               state_in = (acc_ff == '0) ? S_DONE : S_NSET;
            end else begin
               e_in     = e_ff + 4'd1;
               state_in = S_SSET;
            end
         end
         S_NSET: begin
            acc_in    = '0;
            mcand_in  = $signed(AW'(a_ff[e_ff[1:0]]));
            mplier_in = MW'(a_ff[e_ff[1:0]]);
            ret_in    = S_DIVI;
            state_in  = S_MUL;
         end
         S_DIVI: begin
            dq_in    = '0;
            cnt_in   = CNTW'(QW-1);
            state_in = S_DIV;
         end
         S_DIV: begin
            acc_in = $signed({dvr[AW-2:0], 1'b0});
            dq_in  = {dq_ff[QW-2:0], dge};
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) state_in = S_SQI;
         end
         S_SQI: begin
            rq_in    = '0;
            root_in  = '0;
            cnt_in   = CNTW'(RW);
            state_in = S_SQ;
         end
         S_SQ: begin
            rq_in   = sge ? (r2 - trial) : r2;
            root_in = {root_ff[RW-2:0], sge};
            dq_in   = {dq_ff[QW-3:0], 2'b00};
            cnt_in  = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) state_in = S_NOUT;
         end
         S_NOUT: begin
            q_in[e_ff[1:0]] = nclamp;
            if (e_ff == 4'd3) begin
               state_in = S_DONE;
            end else begin
               e_in     = e_ff + 4'd1;
               state_in = S_NSET;
            end
         end
         S_DONE: begin
            if (cmd.ack) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < 9; i++) r_ff[i] <= (i % 4 == 0) ? UNIT : '0;
         q_ff[0] <= UNIT;
         q_ff[1] <= '0;
         q_ff[2] <= '0;
         q_ff[3] <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         q_ff     <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff    <= ret_in;
      e_ff      <= e_in;
      t_ff      <= t_in;
      qmode_ff  <= qmode_in;
      nm_ff     <= nm_in;
      h_ff      <= h_in;
      a_ff      <= a_in;
      sg_ff     <= sg_in;
      s_ff      <= s_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      dq_ff     <= dq_in;
      root_ff   <= root_in;
      rq_ff     <= rq_in;
      cnt_ff    <= cnt_in;
   end

   always_comb begin
      done = (state_ff == S_DONE);
      for (int i = 0; i < 9; i++) mat[i] = r_ff[i];
      for (int i = 0; i < 4; i++) quat[i] = q_ff[i];
   end

endmodule
`default_nettype wire

FILE: design/orientation_integrator.sv
// orientation_integrator: top level with handshakes, registers, counters.
// Time per tick depends on the shift-add multiplier in oi_core, which stops early on small
// operands; an invalid method skips the core. One tick in flight.
// Synchronous reset: identity orientation, counters zero, method 0, default step.
`timescale 1ns / 1ps
`default_nettype none
module orientation_integrator import oi_pkg::*; #(
   parameter int ORIENT_WIDTH = OI_ORIENT_WIDTH,
   parameter int ORIENT_FRAC  = OI_ORIENT_FRAC
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_type                    req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]                csr_wdata
);

   localparam int W = ORIENT_WIDTH;

   logic [1:0]   method_ff;
   logic [31:0]  dt_ff;
   logic         busy_ff, bad_ff, quat_ff, rsp_valid_ff;
   logic [31:0]  step_ff;
   logic [63:0]  elapsed_ff;
   rsp_type      rsp_ff, rsp_in;
   req_type      omega_ff;

   oi_cmd_type             cmd;
   logic                   core_done;
   logic [8:0][W-1:0]      mat;
   logic [3:0][W-1:0]      quat;
   logic signed [W-1:0]    ev [9];
   logic                   accept, method_ok, slot_free, fin;

   assign csr_ready = 1'b1;
   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign accept    = req_valid & ~busy_ff;
   assign method_ok = (method_ff == METHOD_MATRIX) | (method_ff == METHOD_QUAT);
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign fin       = busy_ff & (bad_ff | core_done) & slot_free;

   assign cmd.start = accept & method_ok;
   assign cmd.quat  = (method_ff == METHOD_QUAT);
   assign cmd.ack   = fin;

   oi_core #(
      .ORIENT_WIDTH(ORIENT_WIDTH),
      .ORIENT_FRAC (ORIENT_FRAC)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .dt    (dt_ff),
      .omega (omega_ff),
      .done  (core_done),
      .mat   (mat),
      .quat  (quat)
   );

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         if (quat_ff) ev[i] = (i < 4) ? $signed(quat[i % 4]) : '0;
         else         ev[i] = $signed(mat[i]);
      end
      rsp_in.elem0        = 32'(ev[0]);
      rsp_in.elem1        = 32'(ev[1]);
      rsp_in.elem2        = 32'(ev[2]);
      rsp_in.elem3        = 32'(ev[3]);
      rsp_in.elem4        = 32'(ev[4]);
      rsp_in.elem5        = 32'(ev[5]);
      rsp_in.elem6        = 32'(ev[6]);
      rsp_in.elem7        = 32'(ev[7]);
      rsp_in.elem8        = 32'(ev[8]);
      rsp_in.step_count   = step_ff + 32'd1;
      rsp_in.elapsed_time = elapsed_ff + 64'(dt_ff);
      rsp_in.bad_method   = bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff    <= METHOD_MATRIX;
         dt_ff        <= TIME_STEP_RESET;
         busy_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         quat_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         elapsed_ff   <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_METHOD:    method_ff <= csr_wdata[1:0];
               CSR_TIME_STEP: dt_ff     <= csr_wdata;
               default:       ;
            endcase
         end
         if (accept) begin
            busy_ff <= 1'b1;
            bad_ff  <= ~method_ok;
            quat_ff <= (method_ff == METHOD_QUAT);
         end
         if (fin) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            step_ff      <= rsp_in.step_count;
            elapsed_ff   <= rsp_in.elapsed_time;
         end else if (rsp_valid_ff & ~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) omega_ff <= req_data;
      if (fin)    rsp_ff   <= rsp_in;
   end

endmodule
`default_nettype wire

FILE: dv/orientation_integrator_tb.sv
// orientation_integrator_tb: self-checking bench for the attitude integrator.
// Predicts every tick in matrix, quaternion and invalid-method modes; depends on oi_pkg and the RTL.
`timescale 1ns / 1ps
module orientation_integrator_tb;
   import oi_pkg::*;

   typedef logic signed [255:0] wide_t;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam logic [1:0] METHOD_BAD_LO = 2'd1;
   localparam logic [1:0] METHOD_BAD_HI = 2'd3;
   localparam logic signed [31:0] OMEGA_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] OMEGA_MIN = 32'sh80000000;
   localparam logic signed [31:0] UNIT = 32'sh10000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   always #2 clock = ~clock;

   orientation_integrator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predicted attitude state
   logic signed [31:0] att_mat[9];
   logic signed [31:0] att_quat[4];
   logic [31:0] tick_cnt;
   logic [63:0] time_acc;
   logic [1:0] cur_method;
   logic [31:0] cur_dt;

   rsp_type expected_q[$];
   int errors = 0;
   bit quiet = 1'b0;

   function automatic logic signed [31:0] sat32(wide_t v);
      if (v > wide_t'(OMEGA_MAX)) return OMEGA_MAX;
      if (v < wide_t'(OMEGA_MIN)) return OMEGA_MIN;
      return v[31:0];
   endfunction

   function automatic wide_t round_shift(wide_t v, int n);
      wide_t one;
      one = 1;
      return (v + (one <<< (n - 1))) >>> n;
   endfunction

   task automatic reset_attitude();
      for (int i = 0; i < 9; i++) att_mat[i] = (i % 4 == 0) ? UNIT : '0;
      att_quat[0] = UNIT;
      for (int i = 1; i < 4; i++) att_quat[i] = '0;
      tick_cnt = '0;
      time_acc = '0;
      cur_method = METHOD_MATRIX;
      cur_dt = TIME_STEP_RESET;
   endtask

   function automatic void rotate_matrix(wide_t h[3]);
      wide_t d[9];
      wide_t acc;
      logic signed [31:0] nm[9];
      d[0] = 0;     d[1] = -h[2]; d[2] = h[1];
      d[3] = h[2];  d[4] = 0;     d[5] = -h[0];
      d[6] = -h[1]; d[7] = h[0];  d[8] = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = wide_t'(att_mat[3*i+j]) <<< 52;
            for (int k = 0; k < 3; k++) acc = acc + d[3*i+k] * wide_t'(att_mat[3*k+j]);
            nm[3*i+j] = sat32(round_shift(acc, 52));
         end
      att_mat = nm;
   endfunction

   function automatic void rotate_quat(wide_t h[3]);
      wide_t q[4], p[4], a[4], s, rhs, t, lo, hi, mid;
      logic signed [31:0] nq[4];
      for (int i = 0; i < 4; i++) q[i] = att_quat[i];
      p[0] = -(h[0]*q[1] + h[1]*q[2] + h[2]*q[3]);
      p[1] = h[0]*q[0] + h[1]*q[3] - h[2]*q[2];
      p[2] = h[1]*q[0] + h[2]*q[1] - h[0]*q[3];
      p[3] = h[2]*q[0] + h[0]*q[2] - h[1]*q[1];
      s = 0;
      for (int i = 0; i < 4; i++) begin
         p[i] = round_shift(p[i] + (q[i] <<< 53), 51);
         a[i] = p[i] < 0 ? -p[i] : p[i];
         s = s + a[i] * a[i];
      end
      if (s == 0) return;
      for (int i = 0; i < 4; i++) begin
         rhs = (a[i] * a[i]) <<< 58;
         lo = 0;
         hi = wide_t'(1) <<< 28;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * s <= rhs) lo = mid;
            else hi = mid - 1;
         end
         nq[i] = sat32(p[i] < 0 ? -lo : lo);
      end
      att_quat = nq;
   endfunction

   function automatic rsp_type integrate_tick(req_type r);
      wide_t h[3];
      rsp_type o;
      h[0] = wide_t'({1'b0, cur_dt}) * wide_t'(r.omega_x);
      h[1] = wide_t'({1'b0, cur_dt}) * wide_t'(r.omega_y);
      h[2] = wide_t'({1'b0, cur_dt}) * wide_t'(r.omega_z);
      if (cur_method == METHOD_MATRIX) rotate_matrix(h);
      else if (cur_method == METHOD_QUAT) rotate_quat(h);
      time_acc = time_acc + cur_dt;
      tick_cnt = tick_cnt + 1;
      if (cur_method == METHOD_QUAT)
         o = '{att_quat[0], att_quat[1], att_quat[2], att_quat[3], 32'sd0, 32'sd0, 32'sd0,
               32'sd0, 32'sd0, tick_cnt, time_acc, 1'b0};
      else
         o = '{att_mat[0], att_mat[1], att_mat[2], att_mat[3], att_mat[4], att_mat[5],
               att_mat[6], att_mat[7], att_mat[8], tick_cnt, time_acc,
               cur_method == METHOD_BAD_LO || cur_method == METHOD_BAD_HI};
      return o;
   endfunction

   function automatic logic [63:0] field_of(rsp_type r, int i);
      case (i)
         0: return 64'(r.elem0);
         1: return 64'(r.elem1);
         2: return 64'(r.elem2);
         3: return 64'(r.elem3);
         4: return 64'(r.elem4);
         5: return 64'(r.elem5);
         6: return 64'(r.elem6);
         7: return 64'(r.elem7);
         8: return 64'(r.elem8);
         9: return 64'(r.step_count);
         10: return r.elapsed_time;
         default: return 64'(r.bad_method);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s got %h want %h", $realtime, what, got, want);
      errors++;
   endtask

   // result side: check and random stall
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_data.step_count), '0);
         end else begin
            want = expected_q.pop_front();
            for (int i = 0; i < 12; i++)
               if (field_of(rsp_data, i) !== field_of(want, i))
                  report_mismatch($sformatf("field %0d", i), field_of(rsp_data, i),
                                  field_of(want, i));
         end
      end
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
   end

   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_METHOD) cur_method = value[1:0];
      else if (idx == CSR_TIME_STEP) cur_dt = value;
      @(posedge clock);
   endtask

   task automatic configure(logic [1:0] m, logic [31:0] dt);
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      drain();
      if (m != cur_method) csr_write(CSR_METHOD, {30'd0, m});
      if (dt != cur_dt) csr_write(CSR_TIME_STEP, dt);
   endtask

   task automatic send_tick(req_type r, bit typed, rsp_type typed_rsp);
      rsp_type pred;
      if (!quiet && $urandom_range(99) < 32) begin
         if (req_valid) req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      pred = integrate_tick(r);
      expected_q.push_back(typed ? typed_rsp : pred);
   endtask

   function automatic logic signed [31:0] rand_omega();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return $signed($urandom_range(32'h01ffffff)) - 32'sh01000000;
      if (sel < 80) return $urandom;
      case ($urandom_range(4))
         0: return OMEGA_MAX;
         1: return OMEGA_MIN;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   typedef struct {
      logic [1:0] meth;
      logic [31:0] dt;
      req_type omega;
      bit typed;
      rsp_type want;
   } stim_row_t;

   localparam rsp_type IDENT = '{UNIT, 32'sd0, 32'sd0, 32'sd0, UNIT, 32'sd0, 32'sd0, 32'sd0,
                                 UNIT, 32'd0, 64'd0, 1'b0};

   function automatic rsp_type ident_at(int n, logic [63:0] t, logic bad);
      rsp_type r;
      r = IDENT;
      r.step_count = n;
      r.elapsed_time = t;
      r.bad_method = bad;
      return r;
   endfunction

   initial begin
      stim_row_t rows[$];
      rsp_type none;
      logic [1:0] m;
      none = '0;
      rows.push_back('{METHOD_MATRIX, TIME_STEP_RESET, '{0, 0, 0}, 1,
                       ident_at(1, 64'd42949673, 1'b0)});
      rows.push_back('{METHOD_BAD_LO, TIME_STEP_RESET, '{OMEGA_MAX, OMEGA_MIN, 5}, 1,
                       ident_at(2, 64'd85899346, 1'b1)});
      rows.push_back('{METHOD_BAD_HI, 32'hffffffff, '{OMEGA_MIN, OMEGA_MAX, -1}, 1,
                       ident_at(3, 64'd85899346 + 64'hffffffff, 1'b1)});
      rows.push_back('{METHOD_MATRIX, TIME_STEP_RESET, '{32'sh00100000, 0, 0}, 0, none});
      rows.push_back('{METHOD_MATRIX, TIME_STEP_RESET, '{OMEGA_MAX, OMEGA_MIN, 0}, 0, none});
      rows.push_back('{METHOD_MATRIX, 32'hffffffff, '{OMEGA_MIN, OMEGA_MAX, OMEGA_MAX}, 0,
                       none});
      rows.push_back('{METHOD_MATRIX, 32'd0, '{-1, 1, OMEGA_MIN}, 0, none});
      rows.push_back('{METHOD_QUAT, TIME_STEP_RESET, '{0, 0, 0}, 0, none});
      rows.push_back('{METHOD_QUAT, TIME_STEP_RESET, '{32'sh00100000, -32'sh00200000, 7}, 0,
                       none});
      rows.push_back('{METHOD_QUAT, 32'hffffffff, '{OMEGA_MAX, OMEGA_MAX, OMEGA_MAX}, 0,
                       none});
      rows.push_back('{METHOD_QUAT, 32'hffffffff, '{OMEGA_MIN, OMEGA_MIN, OMEGA_MIN}, 0,
                       none});
      rows.push_back('{METHOD_QUAT, 32'hffffffff, '{OMEGA_MIN, OMEGA_MAX, 0}, 0, none});
      rows.push_back('{METHOD_QUAT, 32'd0, '{OMEGA_MAX, -1, 1}, 0, none});
      rows.push_back('{METHOD_QUAT, 32'd1, '{1, 1, 1}, 0, none});
      rows.push_back('{METHOD_MATRIX, 32'd1, '{OMEGA_MAX, OMEGA_MAX, OMEGA_MAX}, 0, none});

      reset_attitude();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // writes to an unused index are ignored
      csr_write(CSR_UNUSED, 32'hffffffff);

      foreach (rows[i]) begin
         if (rows[i].meth != cur_method || rows[i].dt != cur_dt)
            configure(rows[i].meth, rows[i].dt);
         send_tick(rows[i].omega, rows[i].typed, rows[i].want);
      end

      for (int n = 0; n < 1300; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(9))
               0, 1, 2: m = METHOD_MATRIX;
               3, 4, 5, 6: m = METHOD_QUAT;
               7: m = METHOD_BAD_LO;
               default: m = METHOD_BAD_HI;
            endcase
            case ($urandom_range(5))
               0: configure(m, 32'hffffffff);
               1: configure(m, 32'd0);
               2: configure(m, TIME_STEP_RESET);
               default: configure(m, $urandom_range(32'h02000000));
            endcase
         end
         quiet = (n >= 500 && n < 700);
         send_tick('{rand_omega(), rand_omega(), rand_omega()}, 1'b0, none);
      end
      req_valid <= 1'b0;
      drain();
      repeat (2000) @(posedge clock);
      if (errors == 0) $display("orientation_integrator: match");
      else $display("orientation_integrator: mismatch");
      $finish;
   end

   initial begin
      #80_000_000;
      $display("orientation_integrator: mismatch");
      $finish;
   end

endmodule
